// ===== rtl/core/prsg_pkg.sv =====
// prsg_pkg: types and constants for the padded ramp sample generator
// no dependencies; imported by the channel interfaces and the top level

package prsg_pkg;

  // field widths
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned CODE_W     = 16;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET       = 3'd4;

  // wave modes
  localparam logic [1:0] MODE_DESC = 2'd0;
  localparam logic [1:0] MODE_ASC  = 2'd1;
  localparam logic [1:0] MODE_DIP  = 2'd2;

  // register reset values
  localparam logic [1:0]              RST_WAVE_MODE    = MODE_ASC;
  localparam logic [CNT_W-1:0]        RST_SAMPLE_COUNT = 13'd4096;
  localparam logic [CNT_W-1:0]        RST_PREFIX_COUNT = 13'd100;
  localparam logic signed [MV_W-1:0]  RST_AMPLITUDE    = 16'sd0;
  localparam logic signed [MV_W-1:0]  RST_OFFSET       = 16'sd0;

  // legal ranges in millivolts and half-millivolts
  localparam logic signed [MV_W-1:0] AMP_MAX_MV = 16'sd20000;
  localparam logic signed [MV_W-1:0] OFF_MIN_MV = -16'sd10000;
  localparam logic signed [MV_W-1:0] OFF_MAX_MV = 16'sd10000;
  localparam logic signed [17:0]     HALF_MAX   = 18'sd20000;
  localparam logic signed [17:0]     HALF_MIN   = -18'sd20000;

  // level to counts: floor((65535*(h+20000) + 20000) / 40000), taken as a
  // shift by LVL_SHIFT and then a reciprocal multiply for the remaining /625
  localparam logic signed [18:0]  HALF_BIAS    = 19'sd20000;
  localparam logic [31:0]         CNT_BIAS     = 32'd20000;
  localparam int unsigned         LVL_SHIFT    = 6;
  localparam int unsigned         LVL_X_W      = 32 - LVL_SHIFT;
  localparam int unsigned         DIV625_W     = 27;
  localparam int unsigned         DIV625_SHIFT = 36;
  localparam logic [DIV625_W-1:0] DIV625_MUL   = 27'd109951163;

  // ramp reciprocal scale: recip = floor(2^RECIP_SHIFT / (2*m))
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RECIP_W     = 30;
  localparam int unsigned NUM_W       = 30;
  localparam logic [31:0] RECIP_ONE   = 32'h4000_0000;

  // serial divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 32;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_VALUE   = 2'd1,
    ST_NOTIMPL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_DIV
  } seq_e;

  // per-beat control carried down the pipeline
  typedef struct packed {
    status_e           status;
    logic              last;
    logic              use_fixed;
    logic [CODE_W-1:0] fixed_code;
  } item_ctl_t;

endpackage

// ===== rtl/core/prsg_if.sv =====
// prsg_in_if / prsg_out_if: valid-ready channels of the ramp sample generator
// depends on prsg_pkg for the field widths

interface prsg_in_if import prsg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

interface prsg_out_if import prsg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] sample_code;
  logic              last_sample;
  logic [1:0]        status;

  modport source (output valid, output sample_code, output last_sample, output status,
                  input ready);
  modport sink   (input valid, input sample_code, input last_sample, input status,
                  output ready);
endinterface

// ===== rtl/core/padded_ramp_sample_generator.sv =====
// padded_ramp_sample_generator: DAC code for one position of a padded ramp buffer
// depends on prsg_pkg and the channels in prsg_if.sv
// pipelined; throughput one beat per cycle while in_i.ready is high and out_o.ready does not stall
// ready drops after reset and after every register write, while a serial divider
// (a load state, then the divide steps) forms the ramp reciprocal
// reset: async active low, registers return to their defaults, the pipeline empties

module padded_ramp_sample_generator import prsg_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  prsg_in_if.sink               in_i,
  prsg_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NSTG  = 5;
  localparam int unsigned CNT_DW = $clog2(DIV_STEPS);

  // configuration registers
  logic [1:0]             mode_q;
  logic [CNT_W-1:0]       scount_q;
  logic [CNT_W-1:0]       pcount_q;
  logic signed [MV_W-1:0] amp_q;
  logic signed [MV_W-1:0] off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= RST_WAVE_MODE;
      scount_q <= RST_SAMPLE_COUNT;
      pcount_q <= RST_PREFIX_COUNT;
      amp_q    <= RST_AMPLITUDE;
      off_q    <= RST_OFFSET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WAVE_MODE:    mode_q   <= cfg_data_i[1:0];
        REG_SAMPLE_COUNT: scount_q <= cfg_data_i[CNT_W-1:0];
        REG_PREFIX_COUNT: pcount_q <= cfg_data_i[CNT_W-1:0];
        REG_AMPLITUDE:    amp_q    <= cfg_data_i;
        REG_OFFSET:       off_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // static checks and buffer geometry, settled well before ready returns
  logic signed [17:0] hi_h_w, lo_h_w, zero_h_w;
  logic               cfg_bad_d, cfg_bad_q;
  logic [CNT_W-1:0]   last_idx_q, m_q;
  logic               short_q, desc_q;

  always_comb begin
    zero_h_w = $signed({off_q[15], off_q, 1'b0});
    hi_h_w = $signed({off_q[15], off_q, 1'b0}) + $signed({{2{amp_q[15]}}, amp_q});
    lo_h_w = $signed({off_q[15], off_q, 1'b0}) - $signed({{2{amp_q[15]}}, amp_q});
    cfg_bad_d = (32'(scount_q) > 32'(MAX_SAMPLES)) || (pcount_q >= scount_q) ||
                (amp_q < 16'sd0) || (amp_q > AMP_MAX_MV) ||
                (off_q < OFF_MIN_MV) || (off_q > OFF_MAX_MV) ||
                (hi_h_w > HALF_MAX) || (lo_h_w < HALF_MIN) || (mode_q > MODE_DIP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_bad_q  <= 1'b1;
      last_idx_q <= '0;
      m_q        <= '0;
      short_q    <= 1'b0;
      desc_q     <= 1'b0;
    end else begin
      cfg_bad_q  <= cfg_bad_d;
      last_idx_q <= scount_q - 13'd1;
      m_q        <= scount_q - pcount_q - 13'd2;
      short_q    <= (scount_q - pcount_q - 13'd1) <= 13'd1;
      desc_q     <= mode_q == MODE_DESC;
    end
  end

  // half-millivolt level to 65535*(h+20000)+20000 by shift and subtract, pre-shifted
  function automatic logic [LVL_X_W-1:0] level_scaled(input logic signed [17:0] h);
    logic signed [18:0] a;
    logic [31:0]        num;
    a   = 19'(h) + HALF_BIAS;
    num = ({a[15:0], 16'h0000} - {16'h0000, a[15:0]}) + CNT_BIAS;
    return num[31:LVL_SHIFT];
  endfunction

  // remaining divide by 625 through a reciprocal multiply, exact for this range
  function automatic logic [CODE_W-1:0] level_code(input logic [LVL_X_W-1:0] x);
    logic [LVL_X_W+DIV625_W-1:0] p;
    p = (LVL_X_W + DIV625_W)'(x) * (LVL_X_W + DIV625_W)'(DIV625_MUL);
    return p[DIV625_SHIFT +: CODE_W];
  endfunction

  // level counts, settled through the scaled, code and span registers after a register write
  logic [LVL_X_W-1:0] zero_x_q, lo_x_q, hi_x_q;
  logic [CODE_W-1:0]  zero_q, lo_q, hi_q, d_q;

  always_ff @(posedge clk_i) begin
    zero_x_q <= level_scaled(zero_h_w);
    lo_x_q   <= level_scaled(lo_h_w);
    hi_x_q   <= level_scaled(hi_h_w);
    zero_q   <= level_code(zero_x_q);
    lo_q     <= level_code(lo_x_q);
    hi_q     <= level_code(hi_x_q);
    d_q      <= hi_q - lo_q;
  end

  // serial divider sequencer for the ramp reciprocal
  seq_e                seq_q, seq_d;
  logic [CNT_DW-1:0]   cnt_q;
  logic                seq_busy, div_last;
  logic [15:0]         div_rem_q, div_dsr_q;
  logic [31:0]         div_quo_q;
  logic [16:0]         div_shift_w, div_trial_w;
  logic                div_take_w;
  logic [15:0]         div_rem_w;
  logic [31:0]         div_res_w;
  logic [CNT_W-1:0]    mload_w;
  logic [CNT_W:0]      mdiv_w;

  // next state
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE: seq_d = SEQ_IDLE;
      SEQ_LOAD: seq_d = SEQ_DIV;
      SEQ_DIV: begin
        if (div_last) begin
          seq_d = SEQ_IDLE;
        end
      end
    endcase
    if (cfg_we_i) begin
      seq_d = SEQ_LOAD;
    end
  end

  // sequencer outputs
  always_comb begin
    seq_busy = seq_q != SEQ_IDLE;
    div_last = (seq_q == SEQ_DIV) && (cnt_q == CNT_DW'(DIV_STEPS - 1));
  end

  // divisor straight from the count registers, so the load needs no settling
  always_comb begin
    mdiv_w  = {m_q, 1'b0};
    mload_w = scount_q - pcount_q - 13'd2;
  end

  // one restoring step
  always_comb begin
    div_shift_w = {div_rem_q, div_quo_q[31]};
    div_trial_w = div_shift_w - {1'b0, div_dsr_q};
    div_take_w  = !div_trial_w[16];
    div_rem_w   = div_take_w ? div_trial_w[15:0] : div_shift_w[15:0];
    div_res_w   = {div_quo_q[30:0], div_take_w};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SEQ_LOAD;
      cnt_q <= '0;
    end else begin
      seq_q <= seq_d;
      if (seq_q == SEQ_DIV) begin
        cnt_q <= cnt_q + CNT_DW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // divider datapath
  logic [RECIP_W-1:0] recip_q;

  always_ff @(posedge clk_i) begin
    if (seq_q == SEQ_LOAD) begin
      div_rem_q <= '0;
      div_quo_q <= RECIP_ONE;
      div_dsr_q <= {2'b00, mload_w, 1'b0};
    end else if (seq_q == SEQ_DIV) begin
      div_rem_q <= div_rem_w;
      div_quo_q <= div_res_w;
    end
    if (div_last) begin
      recip_q <= div_res_w[RECIP_W-1:0];
    end
  end

  // pipeline flow control, bubbles collapse
  logic [NSTG-1:0] vld_q, en;
  logic            in_acc;

  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || out_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0] && !seq_busy;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_acc;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 0: classify the index and form the ramp position
  logic [CNT_W-1:0]   idx_w, i_w;
  logic               flat_w;
  item_ctl_t          ctl0_d, ctl0_q, ctl1_q, ctl2_q, ctl3_q;
  logic [CNT_W-1:0]   j0_d, j0_q;

  always_comb begin
    idx_w       = {1'b0, in_i.sample_index};
    ctl0_d.last = idx_w == last_idx_q;
    if (cfg_bad_q || idx_w >= scount_q) begin
      ctl0_d.status = ST_VALUE;
    end else if (mode_q == MODE_DIP) begin
      ctl0_d.status = ST_NOTIMPL;
    end else begin
      ctl0_d.status = ST_OK;
    end
    flat_w            = (idx_w < pcount_q) || (idx_w == last_idx_q);
    ctl0_d.use_fixed  = flat_w || short_q;
    ctl0_d.fixed_code = flat_w ? zero_q : (desc_q ? hi_q : lo_q);
    i_w               = idx_w - pcount_q;
    // a falling ramp is the rising one read from its far end
    j0_d              = desc_q ? (m_q - i_w) : i_w;
  end

  // stage 1: numerator 2*span*j + m
  logic [28:0]       dj_w;
  logic [NUM_W-1:0]  n1_d, n1_q;

  always_comb begin
    dj_w = 29'(d_q) * 29'(j0_q);
    n1_d = {dj_w, 1'b0} + NUM_W'(m_q);
  end

  // stage 2: quotient estimate through the reciprocal
  logic [NUM_W+RECIP_W-1:0] nr_w;
  logic [NUM_W-1:0]         n2_q;
  logic [CODE_W-1:0]        qe2_q;

  assign nr_w = (NUM_W + RECIP_W)'(n1_q) * (NUM_W + RECIP_W)'(recip_q);

  // stage 3: back-multiply and base level
  logic [NUM_W-1:0]  n3_q, qm3_d, qm3_q;
  logic [CODE_W-1:0] base3_d, base3_q;

  always_comb begin
    qm3_d   = NUM_W'(qe2_q) * NUM_W'(mdiv_w);
    base3_d = lo_q + qe2_q;
  end

  // stage 4: estimate correction and final select
  logic [NUM_W-1:0]  r_w;
  logic              inc_w;
  logic [CODE_W-1:0] code4_d, code4_q;
  logic              last4_q;
  status_e           st4_q;

  always_comb begin
    r_w   = n3_q - qm3_q;
    inc_w = r_w >= NUM_W'(mdiv_w);
    if (ctl3_q.status != ST_OK) begin
      code4_d = '0;
    end else if (ctl3_q.use_fixed) begin
      code4_d = ctl3_q.fixed_code;
    end else begin
      code4_d = base3_q + CODE_W'(inc_w);
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ctl0_q <= ctl0_d;
      j0_q   <= j0_d;
    end
    if (en[1]) begin
      ctl1_q <= ctl0_q;
      n1_q   <= n1_d;
    end
    if (en[2]) begin
      ctl2_q <= ctl1_q;
      n2_q   <= n1_q;
      qe2_q  <= nr_w[RECIP_SHIFT +: CODE_W];
    end
    if (en[3]) begin
      ctl3_q  <= ctl2_q;
      n3_q    <= n2_q;
      qm3_q   <= qm3_d;
      base3_q <= base3_d;
    end
    if (en[4]) begin
      code4_q <= code4_d;
      last4_q <= ctl3_q.last;
      st4_q   <= ctl3_q.status;
    end
  end

  // output beat
  assign out_o.valid       = vld_q[NSTG-1];
  assign out_o.sample_code = code4_q;
  assign out_o.last_sample = last4_q;
  assign out_o.status      = st4_q;

  // reciprocal estimate is never more than one below the true quotient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && !seq_busy && ctl3_q.status == ST_OK && !ctl3_q.use_fixed |->
      r_w < NUM_W'({mdiv_w, 1'b0}))
    else $error("ramp quotient correction out of range");

  // a register write holds off input beats while levels are recomputed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_i.ready)
    else $error("input taken right after a register write");

  // failing beats carry a zero code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != ST_OK |-> out_o.sample_code == '0)
    else $error("non-zero code on an error beat");

endmodule
